### rtl/tdpt_pkg.sv
// Shared constants and types for the trial-division prime tester.
package tdpt_pkg;

   // Candidate field width on the request channel
   localparam int CAND_W = 32;
   // Number of candidate bits taken into the test
   localparam int WIDTH  = 32;
   // Divider bit counter width
   localparam int CNT_W  = $clog2(WIDTH);

   localparam int SMALL_PRIME_LO = 2;
   localparam int SMALL_PRIME_HI = 3;
   localparam int FIRST_DIVISOR  = 5;
   localparam int PAIR_OFFSET    = 2;
   localparam int WHEEL_STEP     = 6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV3,
      S_EVAL3,
      S_DIVD,
      S_EVALD,
      S_DIVD2,
      S_EVALD2,
      S_DONE
   } tdpt_state_type;

endpackage

### rtl/tdpt_req_if.sv
// Request channel: one candidate number per item.
interface tdpt_req_if
   import tdpt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CAND_W-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

### rtl/tdpt_rsp_if.sv
// Response channel: one prime flag per item.
interface tdpt_rsp_if
   import tdpt_pkg::*;
();
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink   (input valid, input is_prime, output ready);
endinterface

### rtl/trial_division_prime_test.sv
// Trial-division primality tester built around one shared restoring divider.
//
//   channel   | dir | payload                 | handshake
//   ----------+-----+-------------------------+-------------------
//   req_if    | in  | candidate [31:0] uns.   | valid / ready
//   rsp_if    | out | is_prime               | valid / ready
//
// Trivial values (0, 1, 2, 3, evens) go from idle straight to the done state.
// Otherwise one divide by 3, then per wheel pass up to two divides by d and d+2;
// each divide yields one quotient bit per cycle, then an evaluate state checks it.
// The single divider serves every divide. Reset (synchronous) returns to idle.
// req_if.ready is high only in idle; a result holds until rsp_if.ready.
module trial_division_prime_test
   import tdpt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tdpt_req_if.sink      req_if,
   tdpt_rsp_if.source    rsp_if
);

   tdpt_state_type   state_ff, state_in;

   logic [WIDTH-1:0] n_ff,   n_in;     // candidate under test
   logic [WIDTH-1:0] d_ff,   d_in;     // wheel base, 6k-1
   logic [WIDTH-1:0] div_ff, div_in;   // divisor held by the divider
   logic [WIDTH-1:0] sh_ff,  sh_in;    // dividend bits still to shift in
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             prime_ff, prime_in;

   logic [WIDTH-1:0] cand_n;
   logic             cand_small_prime;
   logic             cand_trivial;
   logic [WIDTH:0]   rem_sh;
   logic             rem_ge;
   logic [WIDTH:0]   rem_sub;
   logic             div_last;
   logic             rem_zero;

   // Bits above WIDTH are dropped
   assign cand_n           = WIDTH'(req_if.candidate);
   assign cand_small_prime = (cand_n == WIDTH'(SMALL_PRIME_LO)) ||
                             (cand_n == WIDTH'(SMALL_PRIME_HI));
   assign cand_trivial     = cand_small_prime || (cand_n <= WIDTH'(1)) || !cand_n[0];

   // Restoring divider step
   assign rem_sh   = {rem_ff, sh_ff[WIDTH-1]};
   assign rem_ge   = rem_sh >= {1'b0, div_ff};
   assign rem_sub  = rem_sh - {1'b0, div_ff};
   assign div_last = (cnt_ff == CNT_W'(WIDTH - 1));
   assign rem_zero = (rem_ff == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               state_in = cand_trivial ? S_DONE : S_DIV3;
            end
         end
         S_DIV3: begin
            if (div_last) state_in = S_EVAL3;
         end
         S_EVAL3: begin
            state_in = rem_zero ? S_DONE : S_DIVD;
         end
         S_DIVD: begin
            if (div_last) state_in = S_EVALD;
         end
         S_EVALD: begin
            // d > n/d ends the search; zero remainder is a factor
            if (d_ff > quo_ff || rem_zero) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DIVD2;
            end
         end
         S_DIVD2: begin
            if (div_last) state_in = S_EVALD2;
         end
         S_EVALD2: begin
            state_in = rem_zero ? S_DONE : S_DIVD;
         end
         S_DONE: begin
            if (rsp_if.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath next values
   always_comb begin
      logic             start_div;
      logic [WIDTH-1:0] start_divisor;

      start_div     = 1'b0;
      start_divisor = div_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      div_in        = div_ff;
      sh_in         = sh_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      prime_in      = prime_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               n_in          = cand_n;
               d_in          = WIDTH'(FIRST_DIVISOR);
               prime_in      = cand_small_prime;
               sh_in         = cand_n;
               start_div     = 1'b1;
               start_divisor = WIDTH'(SMALL_PRIME_HI);
            end
         end
         S_DIV3, S_DIVD, S_DIVD2: begin
            rem_in = rem_ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], rem_ge};
            sh_in  = {sh_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         S_EVAL3: begin
            if (rem_zero) begin
               prime_in = 1'b0;
            end else begin
               start_div     = 1'b1;
               start_divisor = d_ff;
            end
         end
         S_EVALD: begin
            if (d_ff > quo_ff) begin
               prime_in = 1'b1;
            end else if (rem_zero) begin
               prime_in = 1'b0;
            end else begin
               start_div     = 1'b1;
               start_divisor = d_ff + WIDTH'(PAIR_OFFSET);
            end
         end
         S_EVALD2: begin
            if (rem_zero) begin
               prime_in = 1'b0;
            end else begin
               d_in          = d_ff + WIDTH'(WHEEL_STEP);
               start_div     = 1'b1;
               start_divisor = d_ff + WIDTH'(WHEEL_STEP);
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase

      if (start_div) begin
         div_in = start_divisor;
         rem_in = '0;
         quo_in = '0;
         cnt_in = '0;
         if (state_ff != S_IDLE) sh_in = n_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      div_ff   <= div_in;
      sh_ff    <= sh_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
   end

   assign req_if.ready    = (state_ff == S_IDLE);
   assign rsp_if.valid    = (state_ff == S_DONE);
   assign rsp_if.is_prime = prime_ff;

endmodule
